/* src/owse_pkg.sv */
// Shared types and codes for the 1-Wire search ROM decision core.
`default_nettype none
package owse_pkg;

  localparam int unsigned AddrWidth  = 64;
  localparam int unsigned PosWidth   = 7;
  localparam int unsigned CountWidth = 8;
  localparam logic [CountWidth-1:0] MaxDevicesReset = 8'd10;
  localparam logic [CountWidth-1:0] CountMax        = 8'd255;

  typedef enum logic [1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_BEGIN   = 2'd1,
    FUNC_PAIR    = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_DEVICE   = 2'd1,
    STATUS_NO_PRESENCE = 2'd2,
    STATUS_IGNORED     = 2'd3
  } status_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  rom_shift;
    logic [PosWidth-1:0]   bit_position;
    logic [PosWidth-1:0]   zero_branch_pos;
    logic [PosWidth-1:0]   resume_pos;
    logic [CountWidth-1:0] found_count;
    logic                  enumeration_done;
  } search_state_t;

  typedef struct packed {
    logic    direction;
    status_t status;
    logic    pass_complete;
    logic    last_device;
  } search_flags_t;

endpackage
`default_nettype wire

/* src/owse_decide.sv */
// Per-item decision logic: next search state and result flags for one transaction.
`default_nettype none
module owse_decide #(
  parameter int unsigned ADDRESS_BYTES = 8
) (
  input  owse_pkg::func_t                      func,
  input  logic                                 presence,
  input  logic                                 id_bit,
  input  logic                                 comp_bit,
  input  logic [owse_pkg::CountWidth-1:0]      max_devices,
  input  owse_pkg::search_state_t              state_cur,
  output owse_pkg::search_state_t              state_next,
  output owse_pkg::search_flags_t              flags
);

  localparam logic [owse_pkg::PosWidth-1:0] TotalBits =
    owse_pkg::PosWidth'(ADDRESS_BYTES * 8);

  logic                                 pos_valid;
  logic [5:0]                           idx;
  logic                                 dir;
  logic [owse_pkg::PosWidth-1:0]        pos_inc;
  logic [owse_pkg::PosWidth-1:0]        zero_pos;
  logic [owse_pkg::CountWidth-1:0]      count_inc;
  logic                                 last;

  always_comb begin
    pos_valid = (state_cur.bit_position != '0) && (state_cur.bit_position <= TotalBits);
    idx       = 6'(state_cur.bit_position - 7'd1);
    pos_inc   = state_cur.bit_position + 7'd1;
    count_inc = (state_cur.found_count < owse_pkg::CountMax) ?
                state_cur.found_count + 8'd1 : state_cur.found_count;

    // direction choice at this position
    zero_pos = state_cur.zero_branch_pos;
    if (id_bit != comp_bit) begin
      dir = id_bit;
    end else begin
      if (state_cur.bit_position < state_cur.resume_pos) begin
        dir = state_cur.rom_shift[idx];
      end else if (state_cur.bit_position == state_cur.resume_pos) begin
        dir = 1'b1;
      end else begin
        dir = 1'b0;
      end
      if (!dir) begin
        zero_pos = state_cur.bit_position;
      end
    end
    last = (zero_pos == '0);

    state_next          = state_cur;
    flags.direction     = 1'b0;
    flags.status        = owse_pkg::STATUS_OK;
    flags.pass_complete = 1'b0;
    flags.last_device   = 1'b0;

    case (func)
      owse_pkg::FUNC_RESTART: begin
        state_next.rom_shift        = '0;
        state_next.bit_position     = 7'd1;
        state_next.zero_branch_pos  = '0;
        state_next.resume_pos       = '0;
        state_next.found_count      = '0;
        state_next.enumeration_done = 1'b0;
      end
      owse_pkg::FUNC_BEGIN: begin
        if (state_cur.enumeration_done) begin
          flags.status = owse_pkg::STATUS_IGNORED;
        end else if (state_cur.found_count >= max_devices) begin
          state_next.enumeration_done = 1'b1;
          flags.status = owse_pkg::STATUS_IGNORED;
        end else if (!presence) begin
          state_next.enumeration_done = 1'b1;
          flags.status = owse_pkg::STATUS_NO_PRESENCE;
        end else begin
          state_next.bit_position    = 7'd1;
          state_next.zero_branch_pos = '0;
        end
      end
      owse_pkg::FUNC_PAIR: begin
        if (state_cur.enumeration_done || !pos_valid) begin
          flags.status = owse_pkg::STATUS_IGNORED;
        end else if (id_bit && comp_bit) begin
          state_next.enumeration_done = 1'b1;
          flags.status = owse_pkg::STATUS_NO_DEVICE;
        end else begin
          flags.direction            = dir;
          state_next.rom_shift[idx]  = dir;
          state_next.bit_position    = pos_inc;
          state_next.zero_branch_pos = zero_pos;
          if (pos_inc > TotalBits) begin
            flags.pass_complete    = 1'b1;
            flags.last_device      = last;
            state_next.resume_pos  = zero_pos;
            state_next.found_count = count_inc;
            if (last || (count_inc >= max_devices)) begin
              state_next.enumeration_done = 1'b1;
            end
          end
        end
      end
      default: begin
        flags.status = owse_pkg::STATUS_IGNORED;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/onewire_rom_search_engine.sv */
// Top level of the 1-Wire search ROM decision core: input stage, state and result register.
// One transaction per cycle is accepted unless a held result stalls the flow; each one
// yields one result: the item is registered in the input stage, then the decision logic
// updates the search state and fills the result register. in_ready drops only while a
// result is held back by out_ready low with the input stage also full. max_devices is written
// through the cfg channel, always ready, and must only change while the block is idle.
`default_nettype none
module onewire_rom_search_engine #(
  parameter int unsigned ADDRESS_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [owse_pkg::CountWidth-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic                              presence,
  input  logic                              id_bit,
  input  logic                              comp_bit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              direction,
  output logic [1:0]                        status,
  output logic                              pass_complete,
  output logic [owse_pkg::AddrWidth-1:0]    address,
  output logic                              last_device,
  output logic [owse_pkg::CountWidth-1:0]   device_count
);

  logic [owse_pkg::CountWidth-1:0] max_devices;
  owse_pkg::search_state_t         state;
  owse_pkg::search_state_t         state_next;
  owse_pkg::search_flags_t         flags;

  logic            s1_valid;
  owse_pkg::func_t s1_func;
  logic            s1_presence;
  logic            s1_id_bit;
  logic            s1_comp_bit;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_devices <= owse_pkg::MaxDevicesReset;
    end else if (cfg_valid) begin
      max_devices <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func     <= owse_pkg::func_t'(func);
      s1_presence <= presence;
      s1_id_bit   <= id_bit;
      s1_comp_bit <= comp_bit;
    end
  end

  owse_decide #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_decide (
    .func        (s1_func),
    .presence    (s1_presence),
    .id_bit      (s1_id_bit),
    .comp_bit    (s1_comp_bit),
    .max_devices (max_devices),
    .state_cur   (state),
    .state_next  (state_next),
    .flags       (flags)
  );

  // search state advances as the transaction moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.rom_shift        <= '0;
      state.bit_position     <= 7'd1;
      state.zero_branch_pos  <= '0;
      state.resume_pos       <= '0;
      state.found_count      <= '0;
      state.enumeration_done <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      direction     <= flags.direction;
      status        <= flags.status;
      pass_complete <= flags.pass_complete;
      last_device   <= flags.last_device;
      address       <= state_next.rom_shift;
      device_count  <= state_next.found_count;
    end
  end

endmodule
`default_nettype wire
